// ===== hw/rtl/ibus_frame_parser_defines.svh =====
// Assertion macros shared by the frame parser checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef IBUS_FRAME_PARSER_DEFINES_SVH
`define IBUS_FRAME_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IFP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ibus_frame_parser: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define IFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ibus_frame_parser: next-cycle check failed");

`endif

// ===== hw/rtl/ifp_pkg.sv =====
// Package of the frame parser: frame constants, state type and the
// command and status bundles between controller and datapath. No dependencies.
package ifp_pkg;

	localparam int NUM_CHANNELS = 14;
	localparam int BODY_LENGTH  = 30;

	localparam int BYTE_W      = 8;
	localparam int WORD_W      = 16;
	localparam int CH_IDX_W    = 4;
	localparam int COUNT_W     = 6;
	localparam int STORE_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam logic [BYTE_W-1:0]  HDR_FIRST        = 8'h20;
	localparam logic [BYTE_W-1:0]  HDR_SECOND       = 8'h40;
	localparam logic [WORD_W-1:0]  SUM_BASE         = 16'hFFFF;
	localparam logic [COUNT_W-1:0] FIRST_BODY_COUNT = 6'd3;
	localparam logic [COUNT_W-1:0] COUNT_AFTER_HDR0 = 6'd1;
	localparam logic [COUNT_W-1:0] COUNT_AFTER_HDR1 = 6'd2;

	typedef enum logic [2:0] {
		ST_WAIT0 = 3'd0,
		ST_HAVE0 = 3'd1,
		ST_BODY  = 3'd2,
		ST_CKLO  = 3'd3,
		ST_CKHI  = 3'd4,
		ST_EMIT  = 3'd5
	} state_t;

	typedef struct packed {
		logic take_hdr0;
		logic take_hdr1;
		logic take_body;
		logic take_cklo;
		logic clear_all;
		logic emit_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_hdr0;
		logic is_hdr1;
		logic body_end;
		logic sum_ok;
		logic emit_last;
		logic out_free;
	} ctrl_stat_t;

endpackage

// ===== hw/rtl/ifp_if.sv =====
// Stream interfaces of the frame parser: received bytes in, channel words out.
// Depends on ifp_pkg for field widths.
interface ifp_byte_if import ifp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface ifp_chan_if import ifp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CH_IDX_W-1:0] channel_index;
	logic [WORD_W-1:0]   channel_value;
	logic                last_channel;

	modport source (output valid, output channel_index, output channel_value,
		output last_channel, input ready);
	modport sink (input valid, input channel_index, input channel_value,
		input last_channel, output ready);
endinterface

// ===== hw/rtl/ifp_ctrl.sv =====
// Controller of the frame parser: tracks the frame phase and issues
// commands to the datapath. Depends on ifp_pkg.
module ifp_ctrl import ifp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   in_fire;

	assign in_ready = (state_q != ST_EMIT);
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAIT0;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_HAVE0: begin
				if (in_fire) begin
					state_d = stat.is_hdr1 ? ST_BODY : ST_WAIT0;
				end
			end
			ST_BODY: begin
				if (in_fire && stat.body_end) begin
					state_d = ST_CKLO;
				end
			end
			ST_CKLO: begin
				if (in_fire) begin
					state_d = ST_CKHI;
				end
			end
			ST_CKHI: begin
				if (in_fire) begin
					state_d = stat.sum_ok ? ST_EMIT : ST_WAIT0;
				end
			end
			ST_EMIT: begin
				if (stat.out_free && stat.emit_last) begin
					state_d = ST_WAIT0;
				end
			end
			default: begin
				if (in_fire && stat.is_hdr0) begin
					state_d = ST_HAVE0;
				end else begin
					state_d = ST_WAIT0;
				end
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_HAVE0: begin
				if (in_fire) begin
					cmd.take_hdr1 = stat.is_hdr1;
					cmd.clear_all = !stat.is_hdr1;
				end
			end
			ST_BODY: begin
				cmd.take_body = in_fire;
			end
			ST_CKLO: begin
				cmd.take_cklo = in_fire;
			end
			ST_CKHI: begin
				// A good checksum keeps the store for the emit pass.
				cmd.clear_all = in_fire && !stat.sum_ok;
			end
			ST_EMIT: begin
				cmd.emit_load = stat.out_free;
				cmd.clear_all = stat.out_free && stat.emit_last;
			end
			default: begin
				cmd.take_hdr0 = in_fire && stat.is_hdr0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/ifp_datapath.sv =====
// Datapath of the frame parser: byte count, running checksum, channel
// store and the output register. Depends on ifp_pkg.
module ifp_datapath import ifp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [BYTE_W-1:0]   rx_byte,
	input  ctrl_cmd_t           cmd,
	output ctrl_stat_t          stat,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CH_IDX_W-1:0] out_index,
	output logic [WORD_W-1:0]   out_value,
	output logic                out_last
);

	logic [COUNT_W-1:0]     bytes_seen_q;
	logic [WORD_W-1:0]      sum_q;
	logic [BYTE_W-1:0]      check_low_q;
	logic [WORD_W-1:0]      store_q [NUM_CHANNELS];
	logic [STORE_IDX_W-1:0] emit_idx_q;
	logic                   out_valid_q;
	logic [CH_IDX_W-1:0]    out_index_q;
	logic [WORD_W-1:0]      out_value_q;
	logic                   out_last_q;

	logic [COUNT_W-1:0] count_next;
	logic [COUNT_W-1:0] body_pos;
	logic [COUNT_W-1:0] wr_slot;
	logic               wr_in_range;
	logic [WORD_W-1:0]  byte_ext;
	logic               emit_is_last;

	assign byte_ext     = {{(WORD_W - BYTE_W){1'b0}}, rx_byte};
	assign count_next   = bytes_seen_q + 1'b1;
	assign body_pos     = count_next - FIRST_BODY_COUNT;
	assign wr_slot      = body_pos >> 1;
	assign wr_in_range  = (wr_slot < COUNT_W'(NUM_CHANNELS));
	assign emit_is_last = (emit_idx_q == STORE_IDX_W'(NUM_CHANNELS - 1));

	assign stat.is_hdr0   = (rx_byte == HDR_FIRST);
	assign stat.is_hdr1   = (rx_byte == HDR_SECOND);
	assign stat.body_end  = (count_next >= COUNT_W'(BODY_LENGTH));
	assign stat.sum_ok    = ({rx_byte, check_low_q} == sum_q);
	assign stat.emit_last = emit_is_last;
	assign stat.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			sum_q        <= '0;
			check_low_q  <= '0;
			emit_idx_q   <= '0;
			for (int k = 0; k < NUM_CHANNELS; k++) begin
				store_q[k] <= '0;
			end
		end else if (cmd.clear_all) begin
			bytes_seen_q <= '0;
			sum_q        <= '0;
			check_low_q  <= '0;
			emit_idx_q   <= '0;
			for (int k = 0; k < NUM_CHANNELS; k++) begin
				store_q[k] <= '0;
			end
		end else begin
			if (cmd.take_hdr0) begin
				bytes_seen_q <= COUNT_AFTER_HDR0;
				sum_q        <= SUM_BASE - byte_ext;
			end
			if (cmd.take_hdr1) begin
				bytes_seen_q <= COUNT_AFTER_HDR1;
				sum_q        <= sum_q - byte_ext;
			end
			if (cmd.take_body) begin
				bytes_seen_q <= count_next;
				sum_q        <= sum_q - byte_ext;
				// Odd byte counts carry the low half of a channel word.
				for (int k = 0; k < NUM_CHANNELS; k++) begin
					if (wr_in_range && (wr_slot == COUNT_W'(k))) begin
						if (count_next[0]) begin
							store_q[k] <= byte_ext;
						end else begin
							store_q[k][WORD_W-1:BYTE_W] <=
								store_q[k][WORD_W-1:BYTE_W] | rx_byte;
						end
					end
				end
			end
			if (cmd.take_cklo) begin
				check_low_q <= rx_byte;
			end
			if (cmd.emit_load) begin
				emit_idx_q <= emit_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_index_q <= CH_IDX_W'(emit_idx_q);
			out_value_q <= store_q[emit_idx_q];
			out_last_q  <= emit_is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

endmodule

// ===== hw/rtl/ibus_frame_parser.sv =====
// After a good checksum high byte the controller enters the emit state; the output register
// then loads the first channel word. Throughput: one received byte per cycle; after a good
// frame the controller moves the NUM_CHANNELS words out of the channel store, one word per
// cycle unless the sink stalls, via the single output register, taking no byte meanwhile.
// Reset: arst_n clears the phase, byte count, checksum, channel store and output valid.
module ibus_frame_parser import ifp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	ifp_byte_if.sink  rx,
	ifp_chan_if.source chan
);

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;
	logic       in_ready;

	ifp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ifp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx.rx_byte),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (chan.valid),
		.out_ready (chan.ready),
		.out_index (chan.channel_index),
		.out_value (chan.channel_value),
		.out_last  (chan.last_channel)
	);

	assign rx.ready = in_ready;

endmodule

// ===== hw/rtl/ifp_checker.sv =====
// Port-level checks of the frame parser, attached by bind.
// Depends on ifp_pkg and ibus_frame_parser_defines.svh.
`include "ibus_frame_parser_defines.svh"

module ifp_checker import ifp_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                rx_ready,
	input logic                ch_valid,
	input logic                ch_ready,
	input logic [CH_IDX_W-1:0] ch_index,
	input logic [WORD_W-1:0]   ch_value,
	input logic                ch_last
);

	// The last mark belongs only to the final channel.
	`IFP_ASSERT_NOW(a_last_index, ch_valid && ch_last, ch_index == CH_IDX_W'(NUM_CHANNELS - 1))

	// No byte is taken while a frame is still being sent out.
	`IFP_ASSERT_NOW(a_no_rx_mid_frame, ch_valid && !ch_last, !rx_ready)

	// Channels leave back to back in ascending order.
	`IFP_ASSERT_NEXT(a_next_index, ch_valid && ch_ready && !ch_last, ch_valid && (ch_index == CH_IDX_W'($past(ch_index) + 1'b1)))

	`IFP_ASSERT_NEXT(a_stall_hold, ch_valid && !ch_ready, ch_valid && $stable(ch_index) && $stable(ch_value) && $stable(ch_last))

endmodule

bind ibus_frame_parser ifp_checker u_ifp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rx_ready (rx.ready),
	.ch_valid (chan.valid),
	.ch_ready (chan.ready),
	.ch_index (chan.channel_index),
	.ch_value (chan.channel_value),
	.ch_last  (chan.last_channel)
);
